// ----- src/mme_pkg.sv -----
// Shared types, constants and helpers for the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

    localparam int DEF_MAX_DIM = 8;
    localparam int DEF_ELEM_W  = 16;
    localparam int CVAL_W      = 35;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int WIDE_W      = 64;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_RUN
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd2;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_tok;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned maxd);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if ({28'd0, v} > maxd) begin
            res = CFG_W'(maxd);
        end
        return res;
    endfunction

endpackage

// ----- src/mme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mme_ram #(
    parameter int W = 16,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mme_cell.sv -----
// One column cell: holds a column of B, multiplies the passing A word, accumulates, drains.
`timescale 1ns / 1ps

module mme_cell #(
    parameter int MAX_DIM    = mme_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = mme_pkg::DEF_ELEM_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_b_we,
    input  logic [$clog2(MAX_DIM)-1:0]      i_b_idx,
    input  logic signed [ELEM_WIDTH-1:0]    i_b_val,
    input  mme_pkg::t_tok                   i_tok,
    input  logic signed [ELEM_WIDTH-1:0]    i_a,
    output mme_pkg::t_tok                   o_tok,
    output logic signed [ELEM_WIDTH-1:0]    o_a,
    input  logic                            i_shift,
    input  logic [mme_pkg::CVAL_W-1:0]      i_res_next,
    output logic [mme_pkg::CVAL_W-1:0]      o_res
);

    import mme_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int PW = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0] r_b [MAX_DIM];
    logic [IW-1:0]                r_k;
    logic [IW-1:0]                w_idx;
    t_tok                         r_tok;
    logic signed [ELEM_WIDTH-1:0] r_a;
    logic signed [PW-1:0]         r_prod;
    logic signed [WIDE_W-1:0]     w_p64;
    logic [CVAL_W-1:0]            w_p;
    logic [CVAL_W-1:0]            r_acc;
    logic [CVAL_W-1:0]            n_acc;
    logic [CVAL_W-1:0]            r_hold;

    assign w_idx = i_tok.first ? '0 : r_k;
    assign w_p64 = WIDE_W'(r_prod);
    assign w_p   = w_p64[CVAL_W-1:0];
    assign n_acc = r_tok.first ? w_p : r_acc + w_p;

    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_b[i_b_idx] <= i_b_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_k   <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_tok.vld) begin
                r_k <= w_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        if (i_tok.vld) begin
            r_prod <= i_a * r_b[w_idx];
        end
        if (r_tok.vld) begin
            r_acc <= n_acc;
        end
        if (r_tok.vld && r_tok.last) begin
            r_hold <= n_acc;
        end else if (i_shift) begin
            r_hold <= i_res_next;
        end
    end

    assign o_tok = r_tok;
    assign o_a   = r_a;
    assign o_res = r_hold;

endmodule

// ----- src/matrix_multiply_engine.sv -----
// Top level: A store, chain of column cells, run sequencer and stream ports.
// Loads (A or B word) and unknown commands are taken while idle and leave the sequencer idle.
// A run goes row by row: nk A words are fed, they pass through the cell chain,
// then nc output words leave the drain chain.
// The cell chain depth (one stage per column cell) sets the per-row fill time.
// Synchronous active-low reset: configuration registers to 8, sequencer idle; stores undefined.
`timescale 1ns / 1ps

module matrix_multiply_engine #(
    parameter int MAX_DIM    = mme_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = mme_pkg::DEF_ELEM_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,  // row[2:0], col[5:3], value[21:6]
    input  logic [1:0]                      i_s_axis_tuser,  // cmd[1:0]
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [47:0]                     o_m_axis_tdata,  // c_value[34:0], c_row[37:35], c_col[40:38]
    output logic                            o_m_axis_tlast
);

    import mme_pkg::*;

    localparam int IW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_DRAIN
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_rows_a;
    logic [CFG_W-1:0]   r_cols_b;
    logic [CFG_W-1:0]   r_inner;
    logic [CFG_W-1:0]   r_nr;
    logic [CFG_W-1:0]   r_nc;
    logic [CFG_W-1:0]   r_nk;
    logic [IW-1:0]      r_row;
    logic [IW-1:0]      r_col;
    logic [IW-1:0]      r_k;
    logic [CNT_W-1:0]   r_cnt;
    t_tok               r_ftok;

    logic [2:0]                   w_in_row;
    logic [2:0]                   w_in_col;
    logic [15:0]                  w_in_val;
    t_cmd                         w_cmd;
    logic                         w_accept;
    logic                         w_in_range;
    logic signed [WIDE_W-1:0]     w_val64;
    logic [ELEM_WIDTH-1:0]        w_elem;
    logic                         w_a_we;
    logic                         w_b_we;
    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;
    logic [ELEM_WIDTH-1:0]        w_rdata;
    logic                         w_k_last;
    logic                         w_row_last;
    logic                         w_col_last;
    logic                         w_shift;

    t_tok                         w_tok [MAX_DIM+1];
    logic signed [ELEM_WIDTH-1:0] w_a   [MAX_DIM+1];
    logic [CVAL_W-1:0]            w_res [MAX_DIM+1];

    assign w_in_row   = i_s_axis_tdata[2:0];
    assign w_in_col   = i_s_axis_tdata[5:3];
    assign w_in_val   = i_s_axis_tdata[21:6];
    assign w_cmd      = t_cmd'(i_s_axis_tuser);
    assign w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_in_range = ({1'b0, w_in_row} < 4'(MAX_DIM)) && ({1'b0, w_in_col} < 4'(MAX_DIM));
    assign w_val64    = WIDE_W'($signed(w_in_val));
    assign w_elem     = w_val64[ELEM_WIDTH-1:0];
    assign w_a_we     = w_accept && w_in_range && (w_cmd == CMD_LOAD_A);
    assign w_b_we     = w_accept && w_in_range && (w_cmd == CMD_LOAD_B);
    assign w_waddr    = AW'(w_in_row[IW-1:0] * MAX_DIM + w_in_col[IW-1:0]);
    assign w_raddr    = AW'(r_row * MAX_DIM + r_k);

    assign w_k_last   = (CFG_W'(r_k) == r_nk - CFG_W'(1));
    assign w_row_last = (CFG_W'(r_row) == r_nr - CFG_W'(1));
    assign w_col_last = (CFG_W'(r_col) == r_nc - CFG_W'(1));
    assign w_shift    = (r_state == S_DRAIN) && i_m_axis_tready;

    mme_ram #(
        .W (ELEM_WIDTH),
        .D (DEPTH)
    ) u_a_store (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_tok[0]       = r_ftok;
    assign w_a[0]         = $signed(w_rdata);
    assign w_res[MAX_DIM] = '0;

    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        mme_cell #(
            .MAX_DIM    (MAX_DIM),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_b_we     (w_b_we && (w_in_col == 3'(j))),
            .i_b_idx    (w_in_row[IW-1:0]),
            .i_b_val    ($signed(w_elem)),
            .i_tok      (w_tok[j]),
            .i_a        (w_a[j]),
            .o_tok      (w_tok[j+1]),
            .o_a        (w_a[j+1]),
            .i_shift    (w_shift),
            .i_res_next (w_res[j+1]),
            .o_res      (w_res[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= CFG_W'(8);
            r_cols_b <= CFG_W'(8);
            r_inner  <= CFG_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS_A:     r_rows_a <= i_cfg_data;
                REG_COLS_B:     r_cols_b <= i_cfg_data;
                REG_INNER_SIZE: r_inner  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ftok  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_nr    <= CFG_W'(1);
            r_nc    <= CFG_W'(1);
            r_nk    <= CFG_W'(1);
        end else begin
            r_ftok.vld   <= (r_state == S_FEED);
            r_ftok.first <= (r_k == '0);
            r_ftok.last  <= w_k_last;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_cmd == CMD_RUN)) begin
                        r_nr    <= eff_dim(r_rows_a, MAX_DIM);
                        r_nc    <= eff_dim(r_cols_b, MAX_DIM);
                        r_nk    <= eff_dim(r_inner, MAX_DIM);
                        r_row   <= '0;
                        r_k     <= '0;
                        r_state <= S_FEED;
                    end
                end
                S_FEED: begin
                    r_k <= r_k + IW'(1);
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAX_DIM)) begin
                        r_col   <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (i_m_axis_tready) begin
                        if (w_col_last) begin
                            if (w_row_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_row   <= r_row + IW'(1);
                                r_k     <= '0;
                                r_state <= S_FEED;
                            end
                        end else begin
                            r_col <= r_col + IW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_DRAIN);
    assign o_m_axis_tdata  = {7'd0, 3'(r_col), 3'(r_row), w_res[0]};
    assign o_m_axis_tlast  = w_row_last && w_col_last;

endmodule
